// File: src/ssa_pkg.sv
// Shared types and constants for the salted slot allocator.
// No dependencies; used by ssa_ctrl, ssa_datapath and the top level.
package ssa_pkg;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic clr_step;   // write zero at the clear pointer and advance it
    logic accept;     // latch the input word, read its first slot
    logic scan_step;  // move to the next slot and read it
    logic finish;     // commit the operation and load the output word
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;   // clear pointer is on the last slot
    logic scan_more;  // allocate found an occupied slot below the limit
    logic out_free;   // output register can take a word this cycle
  } stat_t;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [15:0] SALT_WRAP        = 16'h8000;
  localparam logic [15:0] SALT_MAX         = 16'hFFFF;
  localparam logic [31:0] HANDLE_NONE      = 32'hFFFF_FFFF;
  localparam logic [10:0] SLOT_LIMIT_RESET = 11'd1024;

endpackage

// File: src/ssa_ctrl.sv
// Controller state machine for the salted slot allocator.
// Depends on ssa_pkg for the state, command and status types.
module ssa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ssa_pkg::stat_t stat,
  output ssa_pkg::cmd_t  cmd,
  output logic           idle
);

  ssa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ssa_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ssa_pkg::S_IDLE;
        end
      end
      ssa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ssa_pkg::S_CHECK;
        end
      end
      ssa_pkg::S_CHECK: begin
        if (stat.scan_more) begin
          cmd.scan_step = 1'b1;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ssa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ssa_pkg::S_CLEAR;
      end
    endcase
  end

  assign idle = (state == ssa_pkg::S_IDLE);

endmodule

// File: src/ssa_datapath.sv
// Datapath for the salted slot allocator: salt memory, scan cursor, counters,
// limit register and output register. Depends on ssa_pkg.
module ssa_datapath #(
  parameter int SLOTS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  ssa_pkg::cmd_t  cmd,
  output ssa_pkg::stat_t stat,
  input  logic           cfg_wr_en,
  input  logic [10:0]    cfg_wr_data,
  input  logic           opcode,
  input  logic [9:0]     slot_index,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     status,
  output logic [31:0]    handle,
  output logic [10:0]    live_slots,
  output logic [10:0]    high_water
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > 11) ? CW : 11;
  localparam logic [LW-1:0] SLOTS_W = LW'(SLOTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

  logic [15:0]   salt_mem [SLOTS];
  logic [15:0]   rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic [AW-1:0] clr_addr;
  logic [10:0]   slot_limit;
  logic          op;
  logic [LW-1:0] cur;
  logic [LW-1:0] cur_inc;
  logic [LW-1:0] index_w;
  logic [LW-1:0] eff_lim;

  logic [CW-1:0] first_free, first_free_next;
  logic [CW-1:0] live_count, live_count_next;
  logic [CW-1:0] high_mark, high_mark_next;
  logic [15:0]   next_salt, next_salt_next;

  logic slot_empty, at_lim, in_range, ok_alloc, ok_rel, commit;
  logic [1:0]  status_next;
  logic [31:0] handle_next;

  // Salt memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      salt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= salt_mem[rd_addr];
    end
  end

  assign index_w = LW'(slot_index);
  assign cur_inc = cur + LW'(1);
  assign eff_lim = (LW'(slot_limit) < SLOTS_W) ? LW'(slot_limit) : SLOTS_W;

  assign rd_en   = cmd.accept | cmd.scan_step;
  assign rd_addr = cmd.accept ? ((opcode == ssa_pkg::OP_ALLOC) ? first_free[AW-1:0]
                                                               : index_w[AW-1:0])
                              : cur_inc[AW-1:0];

  // Cursor is the slot whose salt sits in rd_data
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= opcode;
      cur <= (opcode == ssa_pkg::OP_ALLOC) ? LW'(first_free) : index_w;
    end else if (cmd.scan_step) begin
      cur <= cur_inc;
    end
  end

  assign slot_empty = (rd_data == 16'd0);
  assign at_lim     = (cur >= eff_lim);
  assign in_range   = (cur < SLOTS_W);
  assign ok_alloc   = (op == ssa_pkg::OP_ALLOC) && !at_lim && slot_empty;
  assign ok_rel     = (op == ssa_pkg::OP_RELEASE) && in_range && !slot_empty;
  assign commit     = cmd.finish && (ok_alloc || ok_rel);

  assign wr_en   = cmd.clr_step | commit;
  assign wr_addr = cmd.clr_step ? clr_addr : cur[AW-1:0];
  assign wr_data = (commit && ok_alloc) ? next_salt : 16'd0;

  assign stat.clr_last  = (clr_addr == LAST_ADDR);
  assign stat.scan_more = (op == ssa_pkg::OP_ALLOC) && !at_lim && !slot_empty;
  assign stat.out_free  = !out_valid || !out_stall;

  always_comb begin
    first_free_next = first_free;
    live_count_next = live_count;
    high_mark_next  = high_mark;
    next_salt_next  = next_salt;
    status_next     = ssa_pkg::ST_OK;
    handle_next     = 32'd0;
    if (op == ssa_pkg::OP_ALLOC) begin
      if (ok_alloc) begin
        handle_next     = {next_salt, 16'(cur)};
        next_salt_next  = (next_salt == ssa_pkg::SALT_MAX) ? ssa_pkg::SALT_WRAP
                                                           : next_salt + 16'd1;
        first_free_next = CW'(cur_inc);
        live_count_next = live_count + CW'(1);
        if (LW'(high_mark) <= cur) begin
          high_mark_next = CW'(cur_inc);
        end
      end else begin
        status_next = ssa_pkg::ST_FULL;
        handle_next = ssa_pkg::HANDLE_NONE;
      end
    end else begin
      if (ok_rel) begin
        handle_next = {rd_data, 16'(cur)};
        if (live_count != '0) begin
          live_count_next = live_count - CW'(1);
        end
        if (cur < LW'(first_free)) begin
          first_free_next = CW'(cur);
        end
      end else begin
        status_next = ssa_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      slot_limit <= ssa_pkg::SLOT_LIMIT_RESET;
      first_free <= '0;
      live_count <= '0;
      high_mark  <= '0;
      next_salt  <= ssa_pkg::SALT_WRAP;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_wr_en) begin
        slot_limit <= cfg_wr_data;
      end
      if (commit) begin
        first_free <= first_free_next;
        live_count <= live_count_next;
        high_mark  <= high_mark_next;
        next_salt  <= next_salt_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word payload; counts are taken after the step
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= status_next;
      handle     <= handle_next;
      live_slots <= 11'(live_count_next);
      high_water <= 11'(high_mark_next);
    end
  end

endmodule

// File: src/salted_slot_allocator_core.sv
// Top level of the salted slot allocator: controller plus datapath.
// Depends on ssa_pkg, ssa_ctrl and ssa_datapath.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------------
//  in      | opcode, slot_index                        | in_valid / in_stall
//  out     | status, handle, live_slots, high_water    | out_valid / out_stall
//  cfg     | cfg_wr_data (slot_limit)                  | cfg_wr_en, no wait
//
// After reset a clearing pass zeroes the salt memory, with in_stall high.
// A release reads its own slot once; an allocate reads slots upward from
// the first-free index, skipping occupied ones, one memory read per cycle.
// One word is in flight at a time; the output register holds a finished
// word while the next input word is taken, and a held output word stalls
// only the commit of the following one.
module salted_slot_allocator_core #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [9:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] handle,
  output logic [10:0] live_slots,
  output logic [10:0] high_water
);

  ssa_pkg::cmd_t  cmd;
  ssa_pkg::stat_t stat;
  logic           idle;

  ssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  ssa_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .opcode      (opcode),
    .slot_index  (slot_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .handle      (handle),
    .live_slots  (live_slots),
    .high_water  (high_water)
  );

  assign in_stall = !idle;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for salted_slot_allocator_core: a scoreboard class
// tracks the slot pool and checks every reply word. Depends on ssa_pkg.
module tb_top;

  localparam int SLOT_COUNT = 1024;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle;
    logic [10:0] live;
    logic [10:0] high;
  } pool_reply_t;

  class slot_pool_scoreboard;
    logic [15:0] salt_mem [SLOT_COUNT];
    logic [15:0] next_salt;
    int unsigned first_free, live_count, high_mark, slot_limit;
    int unsigned last_slot, last_freed, salt_wraps;
    int unsigned n_full, n_empty, n_replies, mismatches;
    pool_reply_t due_replies[$];

    function new();
      foreach (salt_mem[i]) salt_mem[i] = 16'd0;
      next_salt  = ssa_pkg::SALT_WRAP;
      first_free = 0;
      live_count = 0;
      high_mark  = 0;
      slot_limit = ssa_pkg::SLOT_LIMIT_RESET;
    endfunction

    // Updates the pool for an accepted request word and queues its reply.
    function void note_request(logic op, logic [9:0] idx);
      pool_reply_t r;
      int unsigned lim, i;
      logic [15:0] old_salt;
      lim = (slot_limit < SLOT_COUNT) ? slot_limit : SLOT_COUNT;
      r.status = ssa_pkg::ST_OK;
      if (op == ssa_pkg::OP_ALLOC) begin
        for (i = first_free; i < lim; i++)
          if (salt_mem[i] == 16'd0) break;
        if (i >= lim) begin
          r.status = ssa_pkg::ST_FULL;
          r.handle = ssa_pkg::HANDLE_NONE;
          n_full++;
        end else begin
          salt_mem[i] = next_salt;
          r.handle = {next_salt, 16'(i)};
          if (next_salt == ssa_pkg::SALT_MAX) begin
            next_salt = ssa_pkg::SALT_WRAP;
            salt_wraps++;
          end else begin
            next_salt = next_salt + 16'd1;
          end
          first_free = i + 1;
          live_count++;
          last_slot = i;
          if (high_mark <= i) high_mark = i + 1;
        end
      end else if (salt_mem[idx] == 16'd0) begin
        r.status = ssa_pkg::ST_EMPTY;
        r.handle = '0;
        n_empty++;
      end else begin
        old_salt = salt_mem[idx];
        salt_mem[idx] = 16'd0;
        if (live_count > 0) live_count--;
        if (idx < first_free) first_free = idx;
        r.handle = {old_salt, 6'd0, idx};
        last_freed = idx;
      end
      r.live = 11'(live_count);
      r.high = 11'(high_mark);
      due_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [31:0] h, logic [10:0] lv,
                              logic [10:0] hw);
      pool_reply_t want, got;
      got = '{st, h, lv, hw};
      n_replies++;
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply word with nothing pending: status %0d handle %h",
                   $time, st, h);
        return;
      end
      want = due_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: reply %0d expected st %0d h %h live %0d high %0d, ",
                 $time, n_replies, want.status, want.handle, want.live,
                 want.high);
          $display("got st %0d h %h live %0d high %0d", st, h, lv, hw);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = ssa_pkg::OP_ALLOC;
  logic [9:0]  slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] handle;
  logic [10:0] live_slots;
  logic [10:0] high_water;

  bit          idle_on = 1'b1;
  int          rx_hold = 0;
  int unsigned words_sent = 0;
  slot_pool_scoreboard sb = new();

  salted_slot_allocator_core #(.SLOTS(SLOT_COUNT)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handle     (handle),
    .live_slots (live_slots),
    .high_water (high_water)
  );

  always #5 clk = ~clk;

  // Reply monitor and receiver stall bursts
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reply(status, handle, live_slots, high_water);
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic issue(input logic op, input logic [9:0] idx);
    opcode     <= op;
    slot_index <= idx;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, idx);
    words_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_replies.size() != 0) @(posedge clk);
  endtask

  // One word in flight at a time, so the block is idle once all replies are in
  task automatic set_limit(input logic [10:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.slot_limit = v;
  endtask

  // Mostly allocates and releases of live slots; some stray releases
  task automatic random_word(input int bias);
    int pick, hi, k;
    logic [9:0] idx;
    pick = $urandom_range(0, 99);
    hi = (sb.high_mark == 0) ? 0 : sb.high_mark - 1;
    if (pick < bias) begin
      issue(ssa_pkg::OP_ALLOC, 10'($urandom_range(0, 1023)));
    end else if (pick < 90) begin
      idx = 10'($urandom_range(0, hi));
      for (k = 0; k < 16; k++) begin
        if (sb.salt_mem[idx] != 16'd0) break;
        idx = 10'($urandom_range(0, hi));
      end
      issue(ssa_pkg::OP_RELEASE, idx);
    end else if (pick < 94) begin
      issue(ssa_pkg::OP_RELEASE, 10'(sb.last_freed));
    end else begin
      issue(ssa_pkg::OP_RELEASE, 10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin
    int seg, bias;
    logic [10:0] lim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // memory clear pass holds off input
    while (in_stall) @(posedge clk);
    set_limit(ssa_pkg::SLOT_LIMIT_RESET);

    // empty releases, fills, slot reuse and scans over occupied slots
    issue(ssa_pkg::OP_RELEASE, 10'd0);
    issue(ssa_pkg::OP_RELEASE, 10'd1023);
    repeat (4) issue(ssa_pkg::OP_ALLOC, 10'd1023);
    issue(ssa_pkg::OP_RELEASE, 10'd2);
    issue(ssa_pkg::OP_RELEASE, 10'd2);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_RELEASE, 10'd0);
    issue(ssa_pkg::OP_RELEASE, 10'd3);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_RELEASE, 10'h2AA);
    issue(ssa_pkg::OP_RELEASE, 10'h155);
    // zero limit: pool always full, release above the limit still works
    set_limit(11'd0);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_RELEASE, 10'd1);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    set_limit(11'd2);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_ALLOC, 10'd0);
    issue(ssa_pkg::OP_RELEASE, 10'd4);
    set_limit(11'd1);
    issue(ssa_pkg::OP_ALLOC, 10'd0);

    for (seg = 0; seg < 10; seg++) begin
      idle_on = (seg % 4 != 3);
      case ($urandom_range(0, 5))
        0:       lim = ssa_pkg::SLOT_LIMIT_RESET;
        1:       lim = 11'($urandom_range(0, 4));
        2:       lim = 11'($urandom_range(65, 1023));
        default: lim = 11'($urandom_range(8, 64));
      endcase
      set_limit(lim);
      bias = $urandom_range(35, 75);
      repeat (38) random_word(bias);
    end

    // Allocate/release pairs on the same slot, no idling from here on
    idle_on = 1'b0;
    set_limit(ssa_pkg::SLOT_LIMIT_RESET);
    repeat (4) begin
      issue(ssa_pkg::OP_ALLOC, 10'($urandom_range(0, 1023)));
      issue(ssa_pkg::OP_RELEASE, 10'(sb.last_slot));
    end

    set_limit(11'($urandom_range(8, 40)));
    repeat (40) random_word(60);
    drain();
    repeat (40) @(posedge clk);

    $display("Run: %0d request words, %0d replies, %0d pool-full, %0d empty releases",
             words_sent, sb.n_replies, sb.n_full, sb.n_empty);
    $display("Salt wrapped %0d time(s); slot limits 0 to 1024 with idle bursts",
             sb.salt_wraps);
    if (sb.mismatches == 0 && sb.due_replies.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
src/ssa_pkg.sv
src/ssa_ctrl.sv
src/ssa_datapath.sv
src/salted_slot_allocator_core.sv
dv/tb_top.sv
